FILE: hw/rtl/lrrc_pkg.sv
// lrrc_pkg: shared types, codes and sizes of the linked band range clipper
// depends on nothing
`default_nettype none

package lrrc_pkg;

  localparam int ROW_BITS   = 8;
  localparam int COL_BITS   = 8;
  localparam int SIZE_BITS  = 9;
  localparam int VAL_BITS   = 16;
  localparam int KIND_BITS  = 3;
  localparam int IDX_BITS   = 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef logic [ROW_BITS-1:0]  row_t;
  typedef logic [COL_BITS-1:0]  col_t;
  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [KIND_BITS-1:0] kind_t;
  typedef logic [VAL_BITS-1:0]  val_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_RANGE  = 1'b1;

  localparam kind_t KIND_COPY   = 3'd0;
  localparam kind_t KIND_SCROLL = 3'd1;

  localparam idx_t REG_SCREEN_LINES   = 2'd0;
  localparam idx_t REG_SCREEN_COLS    = 2'd1;
  localparam idx_t REG_BAND_FIRST_ROW = 2'd2;
  localparam idx_t REG_BAND_LAST_ROW  = 2'd3;

  localparam size_t LINES_RESET = 9'd24;
  localparam size_t COLS_RESET  = 9'd80;
  localparam row_t  BAND_FIRST_RESET = 8'd0;
  localparam row_t  BAND_LAST_RESET  = 8'd23;
  localparam size_t SIZE_MAX = 9'd256;

  typedef struct packed {
    kind_t kind;
    val_t  value;
    col_t  left;
    col_t  right;
    col_t  start_col;
    row_t  start_row;
    col_t  end_col;
    row_t  end_row;
  } res_t;

  typedef struct packed {
    res_t res0;
    res_t res1;
    logic two;
  } job_t;

  function automatic size_t clamp_size(input size_t v);
    size_t r;
    r = v;
    if (v == '0) r = size_t'(1);
    else if (v > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lrrc_in_if.sv
// lrrc_in_if: input channel of the clipper, valid/ready with the item fields
// depends on lrrc_pkg
`default_nettype none

interface lrrc_in_if;
  import lrrc_pkg::*;

  logic  valid;
  logic  ready;
  logic  req_type;
  size_t rows_scrolled;
  kind_t range_kind;
  val_t  range_value;
  col_t  left_col;
  col_t  right_col;
  col_t  first_col;
  row_t  first_row;
  col_t  final_col;
  row_t  final_row;

  modport source (output valid, req_type, rows_scrolled, range_kind, range_value,
                  left_col, right_col, first_col, first_row, final_col, final_row,
                  input ready);
  modport sink (input valid, req_type, rows_scrolled, range_kind, range_value,
                left_col, right_col, first_col, first_row, final_col, final_row,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lrrc_out_if.sv
// lrrc_out_if: result channel of the clipper, valid/ready with the result fields
// depends on lrrc_pkg
`default_nettype none

interface lrrc_out_if;
  import lrrc_pkg::*;

  logic  valid;
  logic  ready;
  kind_t out_kind;
  val_t  out_value;
  col_t  out_left;
  col_t  out_right;
  col_t  out_start_col;
  row_t  out_start_row;
  col_t  out_end_col;
  row_t  out_end_row;
  logic  last_of_run;

  modport source (output valid, out_kind, out_value, out_left, out_right,
                  out_start_col, out_start_row, out_end_col, out_end_row, last_of_run,
                  input ready);
  modport sink (input valid, out_kind, out_value, out_left, out_right,
                out_start_col, out_start_row, out_end_col, out_end_row, last_of_run,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lrrc_front.sv
// lrrc_front: config registers, copy region state, classifies and clips each item
// depends on lrrc_pkg and lrrc_in_if
`default_nettype none

module lrrc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  lrrc_in_if.sink             in_ch,
  input  wire logic           cfg_we,
  input  wire lrrc_pkg::idx_t cfg_index,
  input  wire lrrc_pkg::size_t cfg_data,
  input  wire logic           space,
  output logic                push,
  output lrrc_pkg::job_t      job
);
  import lrrc_pkg::*;

  size_t screen_lines;
  size_t screen_cols;
  row_t  band_first_row;
  row_t  band_last_row;
  logic  copy_active;
  row_t  copy_top;
  row_t  copy_bottom;

  size_t lines;
  row_t  lm1;
  col_t  colmax;
  size_t r;
  logic [SIZE_BITS:0] bf_r;
  logic [SIZE_BITS:0] bl_r;
  size_t bl1;
  logic  hdr_copy;
  row_t  ct_new;
  row_t  cb_new;

  row_t  sr;
  row_t  er;
  col_t  sc;
  col_t  ec;
  row_t  ct_m1;
  row_t  cb_p1;
  logic  drop;
  res_t  base;
  res_t  rng0;
  res_t  rng1;
  logic  rng_two;

  logic  accept;

  assign in_ch.ready = space;
  assign accept = in_ch.valid && space;

  always_comb begin
    lines  = clamp_size(screen_lines);
    lm1    = row_t'(lines - size_t'(1));
    colmax = col_t'(clamp_size(screen_cols) - size_t'(1));
    r      = (in_ch.rows_scrolled > SIZE_MAX) ? SIZE_MAX : in_ch.rows_scrolled;
    bf_r   = (SIZE_BITS+1)'(band_first_row) + (SIZE_BITS+1)'(r);
    bl_r   = (SIZE_BITS+1)'(band_last_row) + (SIZE_BITS+1)'(r);
    bl1    = size_t'(band_last_row) + size_t'(1);
    hdr_copy = (band_last_row != lm1) && (bf_r <= (SIZE_BITS+1)'(lm1));
    ct_new = (bf_r < (SIZE_BITS+1)'(bl1)) ? row_t'(bl1 - r) : band_first_row;
    cb_new = (bl_r > (SIZE_BITS+1)'(lm1)) ? row_t'(size_t'(lm1) - r) : band_last_row;
  end

  always_comb begin
    sr = in_ch.first_row;
    sc = in_ch.first_col;
    er = in_ch.final_row;
    ec = in_ch.final_col;
    if (sr < band_first_row) begin
      sr = band_first_row;
      sc = in_ch.left_col;
    end
    if (er > band_last_row) begin
      er = band_last_row;
      ec = in_ch.right_col;
    end
    ct_m1 = copy_top - row_t'(1);
    cb_p1 = copy_bottom + row_t'(1);
    drop = (in_ch.final_row < band_first_row) || (in_ch.first_row > band_last_row) ||
           (copy_active && (sr >= copy_top) && (er <= copy_bottom));

    base.kind  = in_ch.range_kind;
    base.value = in_ch.range_value;
    base.left  = in_ch.left_col;
    base.right = in_ch.right_col;
    base.start_col = sc;
    base.start_row = sr;
    base.end_col   = ec;
    base.end_row   = er;
    rng0 = base;
    rng1 = base;
    rng_two = 1'b0;
    if (copy_active) begin
      if (sr >= copy_top && sr <= copy_bottom) begin
        rng0.start_row = cb_p1;
        rng0.start_col = in_ch.left_col;
      end else if (er >= copy_top && er <= copy_bottom) begin
        rng0.end_row = ct_m1;
        rng0.end_col = in_ch.right_col;
      end else if (sr < copy_top && er > copy_bottom) begin
        rng_two = 1'b1;
        rng0.end_col = in_ch.right_col;
        rng0.end_row = ct_m1;
        rng1.start_col = in_ch.left_col;
        rng1.start_row = cb_p1;
      end
    end
  end

  always_comb begin
    job = '0;
    if (in_ch.req_type == REQ_HEADER) begin
      job.res0.kind      = KIND_SCROLL;
      job.res0.value     = val_t'(r);
      job.res0.left      = '0;
      job.res0.right     = colmax;
      job.res0.start_col = '0;
      job.res0.start_row = band_first_row;
      job.res0.end_col   = colmax;
      job.res0.end_row   = band_last_row;
      job.res1.kind      = KIND_COPY;
      job.res1.value     = '0;
      job.res1.left      = '0;
      job.res1.right     = colmax;
      job.res1.start_col = '0;
      job.res1.start_row = ct_new;
      job.res1.end_col   = colmax;
      job.res1.end_row   = cb_new;
      job.two            = hdr_copy;
      push = accept && (r != '0);
    end else begin
      job.res0 = rng0;
      job.res1 = rng1;
      job.two  = rng_two;
      push = accept && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_lines   <= LINES_RESET;
      screen_cols    <= COLS_RESET;
      band_first_row <= BAND_FIRST_RESET;
      band_last_row  <= BAND_LAST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_LINES:   screen_lines   <= cfg_data;
        REG_SCREEN_COLS:    screen_cols    <= cfg_data;
        REG_BAND_FIRST_ROW: band_first_row <= row_t'(cfg_data);
        REG_BAND_LAST_ROW:  band_last_row  <= row_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_active <= 1'b0;
      copy_top    <= '0;
      copy_bottom <= '0;
    end else if (accept && in_ch.req_type == REQ_HEADER) begin
      copy_active <= (r != '0) && hdr_copy;
      if ((r != '0) && hdr_copy) begin
        copy_top    <= ct_new;
        copy_bottom <= cb_new;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lrrc_queue.sv
// lrrc_queue: short job queue between the front and back parts
// depends on lrrc_pkg
`default_nettype none

module lrrc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lrrc_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                space,
  output logic                head_valid,
  output lrrc_pkg::job_t      head
);
  import lrrc_pkg::*;

  job_t mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign space      = (count != QCNT_BITS'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lrrc_back.sv
// lrrc_back: issues one or two results per job through the output register
// depends on lrrc_pkg and lrrc_out_if
`default_nettype none

module lrrc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire lrrc_pkg::job_t head,
  output logic                pop,
  lrrc_out_if.source          out_ch
);
  import lrrc_pkg::*;

  logic ovalid;
  logic half;
  res_t ores;
  logic olast;
  logic load;

  assign load = !ovalid || out_ch.ready;
  assign pop  = load && head_valid && (!head.two || half);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      half   <= 1'b0;
    end else if (load) begin
      ovalid <= head_valid;
      if (head_valid) half <= head.two && !half;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      ores  <= half ? head.res1 : head.res0;
      olast <= !head.two || half;
    end
  end

  assign out_ch.valid         = ovalid;
  assign out_ch.out_kind      = ores.kind;
  assign out_ch.out_value     = ores.value;
  assign out_ch.out_left      = ores.left;
  assign out_ch.out_right     = ores.right;
  assign out_ch.out_start_col = ores.start_col;
  assign out_ch.out_start_row = ores.start_row;
  assign out_ch.out_end_col   = ores.end_col;
  assign out_ch.out_end_row   = ores.end_row;
  assign out_ch.last_of_run   = olast;

endmodule

`default_nettype wire

FILE: hw/rtl/link_region_range_clipper.sv
// link_region_range_clipper: top level, front classifier, job queue, result issue
// depends on lrrc_pkg, lrrc_in_if, lrrc_out_if, lrrc_front, lrrc_queue, lrrc_back
//
// channel   direction  handshake     carries
// in_ch     in         valid/ready   header (lines scrolled) or one range item
// out_ch    out        valid/ready   one clipped range, last_of_run on the final one
// cfg       in         cfg_we        register index and data, no read-back
//
// an item is taken every cycle while the four-entry job queue has room
// headers and ranges give zero, one or two results; the result register
// issues one result per cycle while out_ch is ready, so a split range or
// a header with a copy range gives its two results in turn
// an accepted item is registered in the job queue, then in the output register
// reset is synchronous; out_ch stalls back up into the queue
`default_nettype none

module link_region_range_clipper (
  input  wire logic            clk,
  input  wire logic            rst,
  lrrc_in_if.sink              in_ch,
  lrrc_out_if.source           out_ch,
  input  wire logic            cfg_we,
  input  wire lrrc_pkg::idx_t  cfg_index,
  input  wire lrrc_pkg::size_t cfg_data
);
  import lrrc_pkg::*;

  logic space;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head;

  lrrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .space     (space),
    .push      (push),
    .job       (push_job)
  );

  lrrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .space      (space),
    .head_valid (head_valid),
    .head       (head)
  );

  lrrc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  a_split_follows: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=>
      (out_ch.valid && out_ch.last_of_run))
    else $error("second half of a two-result item did not follow");

  a_no_result_from_empty: assert property (@(posedge clk) disable iff (rst)
    (!head_valid && !out_ch.valid) |=> !out_ch.valid)
    else $error("result appeared with an empty job queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job queue popped while empty");
`endif

endmodule

`default_nettype wire
